/* src/tcl_pkg.sv */
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants for the timed cue lookup block.
// ----------------------------------------------------------------------------
package tcl_pkg;

  // Default table depth
  localparam int unsigned MAX_CUES_DEF = 1024;

  // Field widths
  localparam int unsigned TICKS_W  = 41;  // stored start time in ticks
  localparam int unsigned PTS_W    = 42;  // presentation time / duration
  localparam int unsigned MS_W     = 31;  // start time in milliseconds
  localparam int unsigned CUE_IX_W = 10;  // reported cue index

  // Time constants in microsecond ticks
  localparam logic [9:0]       TICKS_PER_MS   = 10'd1000;
  localparam logic [PTS_W-1:0] LAST_CUE_TICKS = 42'd8000000;
  localparam logic [PTS_W-1:0] MIN_SHOW_TICKS = 42'd200000;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_NONE    = 3'd0,
    STAT_SHOW    = 3'd1,
    STAT_SILENT  = 3'd2,
    STAT_DROP    = 3'd3,
    STAT_LOADED  = 3'd4,
    STAT_FULL    = 3'd5,
    STAT_CLEARED = 3'd6
  } status_e;

  // One table entry
  typedef struct packed {
    logic               text;
    logic [TICKS_W-1:0] ticks;
  } cue_entry_t;

endpackage

/* src/tcl_cue_mem.sv */
// ----------------------------------------------------------------------------
// tcl_cue_mem
// Cue table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcl_cue_mem import tcl_pkg::*; #(
  parameter int unsigned DEPTH = MAX_CUES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  cue_entry_t        wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output cue_entry_t        rdata_o
);

  cue_entry_t mem_q [DEPTH];
  cue_entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/tcl_apb_regs.sv */
// ----------------------------------------------------------------------------
// tcl_apb_regs
// Register port holding the display enable bit.
// ----------------------------------------------------------------------------
module tcl_apb_regs import tcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        show_en_o
);

  logic show_en_d, show_en_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready & (paddr == 2'd0);

  // Enable register
  always_comb begin
    show_en_d = show_en_q;
    if (wr_en) begin
      show_en_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_en_q <= 1'b0;
    end else begin
      show_en_q <= show_en_d;
    end
  end

  // Read back
  assign prdata    = (paddr == 2'd0) ? {31'd0, show_en_q} : 32'd0;
  assign show_en_o = show_en_q;

endmodule

/* src/tcl_ctrl.sv */
// ----------------------------------------------------------------------------
// tcl_ctrl
// Request sequencer: table loads and clears, binary search over the cue memory,
// duration computation and the output result register.
// ----------------------------------------------------------------------------
module tcl_ctrl import tcl_pkg::*; #(
  parameter int unsigned MAX_CUES = MAX_CUES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  show_en_i,
  // request side
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  op_e                                   in_op_i,
  input  logic [MS_W-1:0]                       in_start_ms_i,
  input  logic                                  in_has_text_i,
  input  logic [PTS_W-1:0]                      in_pts_i,
  input  logic                                  in_pts_valid_i,
  // result side
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output status_e                               out_status_o,
  output logic [CUE_IX_W-1:0]                   out_cue_index_o,
  output logic [PTS_W-1:0]                      out_duration_o,
  // cue memory
  output logic                                  mem_we_o,
  output logic [$clog2(MAX_CUES)-1:0]           mem_waddr_o,
  output cue_entry_t                            mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [$clog2(MAX_CUES)-1:0]           mem_raddr_o,
  input  cue_entry_t                            mem_rdata_i
);

  localparam int unsigned IDX_W = $clog2(MAX_CUES);
  localparam int unsigned CNT_W = $clog2(MAX_CUES + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_NEXT   = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e state_d, state_q;

  logic [CNT_W-1:0]   cnt_q;
  logic               cur_v_q;
  logic [IDX_W-1:0]   cur_idx_q;
  logic [CNT_W-1:0]   lo_q, end_q;
  logic [IDX_W-1:0]   mid_q;
  logic               rd_pend_q;
  logic               found_v_q;
  logic [IDX_W-1:0]   found_q;
  logic [TICKS_W-1:0] found_ticks_q;
  logic               found_text_q;
  logic [PTS_W-1:0]   pts_q;

  status_e             res_status_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic [PTS_W-1:0]    res_dur_q;

  logic                out_valid_q;
  status_e             out_status_q;
  logic [CUE_IX_W-1:0] out_idx_q;
  logic [PTS_W-1:0]    out_dur_q;

  logic               accept;
  logic               full;
  logic               hit;
  logic [CNT_W-1:0]   lo_n, end_n;
  logic               fv_n;
  logic [IDX_W-1:0]   found_n;
  logic [TICKS_W-1:0] ft_n;
  logic               text_n;
  logic [CNT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid_n;
  logic               more;
  logic               same_cue;
  logic               has_next;
  logic [PTS_W-1:0]   diff;
  logic [PTS_W-1:0]   dur_n;
  logic               out_free;
  logic [31:0]        idx_ext;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign full       = (cnt_q == CNT_W'(MAX_CUES));
  assign out_free   = ~out_valid_q | out_ready_i;

  // Search step: fold in the compare of the entry read last cycle
  always_comb begin
    hit     = rd_pend_q & ({1'b0, mem_rdata_i.ticks} <= pts_q);
    lo_n    = (rd_pend_q & hit)  ? CNT_W'(mid_q) + CNT_W'(1) : lo_q;
    end_n   = (rd_pend_q & ~hit) ? CNT_W'(mid_q) : end_q;
    fv_n    = found_v_q | hit;
    found_n = hit ? mid_q : found_q;
    ft_n    = hit ? mem_rdata_i.ticks : found_ticks_q;
    text_n  = hit ? mem_rdata_i.text : found_text_q;
    mid_sum = {1'b0, lo_n} + {1'b0, end_n} - (CNT_W+1)'(1);
    mid_n   = mid_sum[IDX_W:1];
    more    = (lo_n < end_n);
    same_cue = cur_v_q & (found_n == cur_idx_q);
    has_next = (CNT_W'(found_n) + CNT_W'(1)) < cnt_q;
  end

  // Gap to the next cue, clamped to the minimum show time
  always_comb begin
    diff  = {1'b0, mem_rdata_i.ticks} - {1'b0, found_ticks_q};
    dur_n = (diff[PTS_W-1] || (diff < MIN_SHOW_TICKS)) ? MIN_SHOW_TICKS : diff;
  end

  // Memory access
  always_comb begin
    mem_we_o          = 1'b0;
    mem_waddr_o       = cnt_q[IDX_W-1:0];
    mem_wdata_o.text  = in_has_text_i;
    mem_wdata_o.ticks = TICKS_W'(TICKS_W'(in_start_ms_i) * TICKS_W'(TICKS_PER_MS));
    mem_re_o          = 1'b0;
    mem_raddr_o       = mid_n;
    if (accept && (in_op_i == OP_LOAD) && !full) begin
      mem_we_o = 1'b1;
    end
    if (state_q == ST_SEARCH) begin
      if (more) begin
        mem_re_o = 1'b1;
      end else if (fv_n && !same_cue && text_n && has_next) begin
        mem_re_o    = 1'b1;
        mem_raddr_o = found_n + IDX_W'(1);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((in_op_i == OP_QUERY) && show_en_i && (cnt_q != '0) && in_pts_valid_i) begin
            state_d = ST_SEARCH;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SEARCH: begin
        if (!more) begin
          if (fv_n && !same_cue && text_n && has_next) begin
            state_d = ST_NEXT;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_NEXT: state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_v_q     <= 1'b0;
      cur_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      found_v_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && accept) begin
        unique case (in_op_i)
          OP_LOAD: begin
            if (!full) begin
              cnt_q <= cnt_q + CNT_W'(1);
            end
          end
          OP_QUERY: begin
            if (!show_en_i) begin
              cur_v_q   <= 1'b0;
              cur_idx_q <= '0;
            end
          end
          OP_CLEAR: begin
            cnt_q     <= '0;
            cur_v_q   <= 1'b0;
            cur_idx_q <= '0;
          end
          default: ;
        endcase
        rd_pend_q <= 1'b0;
        found_v_q <= 1'b0;
      end
      if (state_q == ST_SEARCH) begin
        rd_pend_q <= more;
        found_v_q <= fv_n;
        if (!more && fv_n && !same_cue) begin
          cur_v_q   <= 1'b1;
          cur_idx_q <= found_n;
        end
      end
      if (state_q == ST_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      lo_q      <= '0;
      end_q     <= cnt_q;
      pts_q     <= in_pts_i;
      res_idx_q <= '0;
      res_dur_q <= '0;
      unique case (in_op_i)
        OP_LOAD:  res_status_q <= full ? STAT_FULL : STAT_LOADED;
        OP_QUERY: res_status_q <= (!show_en_i && cur_v_q) ? STAT_DROP : STAT_NONE;
        OP_CLEAR: res_status_q <= STAT_CLEARED;
        default:  res_status_q <= STAT_NONE;
      endcase
    end
    if (state_q == ST_SEARCH) begin
      lo_q          <= lo_n;
      end_q         <= end_n;
      mid_q         <= mid_n;
      found_q       <= found_n;
      found_ticks_q <= ft_n;
      found_text_q  <= text_n;
      if (!more) begin
        if (!fv_n || same_cue) begin
          res_status_q <= STAT_NONE;
          res_idx_q    <= '0;
        end else if (!text_n) begin
          res_status_q <= STAT_SILENT;
          res_idx_q    <= found_n;
        end else begin
          res_status_q <= STAT_SHOW;
          res_idx_q    <= found_n;
          res_dur_q    <= LAST_CUE_TICKS;
        end
      end
    end
    if (state_q == ST_NEXT) begin
      res_dur_q <= dur_n;
    end
    if (state_q == ST_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_ext[CUE_IX_W-1:0];
      out_dur_q    <= res_dur_q;
    end
  end

  assign idx_ext = 32'(res_idx_q);

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_cue_index_o = out_idx_q;
  assign out_duration_o  = out_dur_q;

`ifndef SYNTHESIS
  // Table count never exceeds the depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CUES))
    else $error("cue count beyond table depth");

  // The current cue always lies inside the loaded table
  a_cur_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_v_q |-> (CNT_W'(cur_idx_q) < cnt_q))
    else $error("current cue outside table");

  // Loads and searches never share a memory cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("memory read and write in one cycle");

  // The duration step always follows a read of the next entry
  a_next_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_NEXT) |-> $past(mem_re_o))
    else $error("duration step without memory read");
`endif

endmodule

/* src/timed_cue_lookup_top.sv */
// ----------------------------------------------------------------------------
// timed_cue_lookup_top
// Cue table with binary search lookup of the cue active at a given time.
//
//   channel   dir  handshake                fields
//   s_axis    in   s_axis_tvalid/tready     tuser: operation, pts_valid
//                                           tdata: start_ms, has_text, pts
//   m_axis    out  m_axis_tvalid/tready     tuser: status
//                                           tdata: cue_index, duration
//   apb       in   psel/penable/pready      show_enable at address 0
//
// One request at a time. Loads, clears and queries that need no search go
// straight to the result state. A searching query runs a binary search through
// the single read port of the cue memory (one probe per cycle), plus one read
// of the next cue for a shown cue.
// A new request is taken while the previous result still waits on m_axis.
// Reset clears count and current cue; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module timed_cue_lookup_top import tcl_pkg::*; #(
  parameter int unsigned MAX_CUES = MAX_CUES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // start_ms[30:0], has_text[31], pts[73:32], pad
  input  logic [2:0]  s_axis_tuser_i,  // operation[1:0], pts_valid[2]
  // results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // cue_index[9:0], duration[51:10], pad
  output logic [2:0]  m_axis_tuser_o,  // status[2:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = $clog2(MAX_CUES);

  logic                show_en;
  logic                mem_we, mem_re;
  logic [IDX_W-1:0]    mem_waddr, mem_raddr;
  cue_entry_t          mem_wdata, mem_rdata;
  status_e             out_status;
  logic [CUE_IX_W-1:0] out_idx;
  logic [PTS_W-1:0]    out_dur;

  // Configuration register
  tcl_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .show_en_o (show_en)
  );

  // Cue table
  tcl_cue_mem #(
    .DEPTH (MAX_CUES),
    .AW    (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequencer
  tcl_ctrl #(
    .MAX_CUES (MAX_CUES)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .show_en_i       (show_en),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .in_op_i         (op_e'(s_axis_tuser_i[1:0])),
    .in_start_ms_i   (s_axis_tdata_i[30:0]),
    .in_has_text_i   (s_axis_tdata_i[31]),
    .in_pts_i        (s_axis_tdata_i[73:32]),
    .in_pts_valid_i  (s_axis_tuser_i[2]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_status_o    (out_status),
    .out_cue_index_o (out_idx),
    .out_duration_o  (out_dur),
    .mem_we_o        (mem_we),
    .mem_waddr_o     (mem_waddr),
    .mem_wdata_o     (mem_wdata),
    .mem_re_o        (mem_re),
    .mem_raddr_o     (mem_raddr),
    .mem_rdata_i     (mem_rdata)
  );

  assign m_axis_tdata_o = {4'd0, out_dur, out_idx};
  assign m_axis_tuser_o = out_status;

endmodule

/* tb/sv/tcl_cue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcl_cue_checker
// Passive scoreboard for the timed cue lookup block: it mirrors the cue
// table and current cue, predicts the result of every accepted request
// and compares it field by field with the results leaving the block.
// ----------------------------------------------------------------------------
module tcl_cue_checker import tcl_pkg::*; #(
  parameter int unsigned DEPTH        = MAX_CUES_DEF,
  parameter logic [1:0]  SHOW_EN_ADDR = 2'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [79:0] req_data_i,  // start_ms[30:0], has_text[31], pts[73:32], pad
  input  logic [2:0]  req_user_i,  // operation[1:0], pts_valid[2]
  // result channel
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [55:0] res_data_i,  // cue_index[9:0], duration[51:10], pad
  input  logic [2:0]  res_user_i,  // status[2:0]
  // register bus
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  // summary towards the testbench top
  output int          err_cnt_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    status_e               status;
    logic [CUE_IX_W-1:0]   index;
    logic [PTS_W-1:0]      duration;
  } cue_result_t;

  // Mirror of the block state
  logic [TICKS_W-1:0] start_tbl [DEPTH];
  logic               text_tbl  [DEPTH];
  int unsigned        n_cues;
  logic               cur_valid;
  int unsigned        cur_idx;
  logic               show_en;

  cue_result_t        due_results [$];
  int                 err_cnt = 0;
  int                 checked = 0;
  int                 pending = 0;

  assign err_cnt_o = err_cnt;
  assign pending_o = pending;
  assign checked_o = checked;

  // Binary search for the last cue starting at or before pts
  function automatic cue_result_t lookup_cue(logic [PTS_W-1:0] pts, logic pts_ok);
    int               lo;
    int               hi;
    int               mid;
    int               hit;
    logic [PTS_W-1:0] gap;
    cue_result_t      r;
    r.status   = STAT_NONE;
    r.index    = '0;
    r.duration = '0;
    if (!show_en) begin
      if (cur_valid) begin
        cur_valid = 1'b0;
        cur_idx   = 0;
        r.status  = STAT_DROP;
      end
      return r;
    end
    if (n_cues == 0 || !pts_ok) return r;
    lo  = 0;
    hi  = int'(n_cues) - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if ({1'b0, start_tbl[mid]} <= pts) begin
        hit = mid;
        lo  = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    if (hit < 0 || (cur_valid && hit == int'(cur_idx))) return r;
    cur_valid = 1'b1;
    cur_idx   = hit;
    r.index   = hit[CUE_IX_W-1:0];
    if (!text_tbl[hit]) begin
      r.status = STAT_SILENT;
      return r;
    end
    // gap to the next cue, 8 s for the last one, never under 200 ms
    if (hit + 1 < int'(n_cues)) begin
      gap = (start_tbl[hit+1] > start_tbl[hit]) ?
            PTS_W'(start_tbl[hit+1] - start_tbl[hit]) : '0;
    end else begin
      gap = LAST_CUE_TICKS;
    end
    if (gap < MIN_SHOW_TICKS) gap = MIN_SHOW_TICKS;
    r.status   = STAT_SHOW;
    r.duration = gap;
    return r;
  endfunction

  // Advance the mirror by one request and return its result
  function automatic cue_result_t apply_request(logic [1:0] op, logic [79:0] data,
                                                logic pts_ok);
    cue_result_t r;
    r.status   = STAT_NONE;
    r.index    = '0;
    r.duration = '0;
    case (op)
      OP_LOAD: begin
        if (n_cues >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          start_tbl[n_cues] = TICKS_W'(data[30:0]) * TICKS_W'(TICKS_PER_MS);
          text_tbl[n_cues]  = data[31];
          n_cues++;
          r.status = STAT_LOADED;
        end
      end
      OP_QUERY: begin
        r = lookup_cue(data[73:32], pts_ok);
      end
      OP_CLEAR: begin
        n_cues    = 0;
        cur_valid = 1'b0;
        cur_idx   = 0;
        r.status  = STAT_CLEARED;
      end
      default: ;  // unused code: nothing happens
    endcase
    return r;
  endfunction

  // Compare outgoing results, track register writes, queue predictions
  always @(posedge clk_i or negedge rst_ni) begin
    cue_result_t want;
    if (!rst_ni) begin
      n_cues    = 0;
      cur_valid = 1'b0;
      cur_idx   = 0;
      show_en   = 1'b0;
      due_results.delete();
    end else begin
      // a result never belongs to a request taken at the same edge
      if (res_valid_i && res_ready_i) begin
        if (due_results.size() == 0) begin
          $error("result without outstanding request: status %0d", res_user_i);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (res_user_i != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_user_i);
            err_cnt++;
          end
          if (res_data_i[9:0] != want.index) begin
            $error("cue_index: expected %0d, actual %0d", want.index, res_data_i[9:0]);
            err_cnt++;
          end
          if (res_data_i[51:10] != want.duration) begin
            $error("duration: expected %0d, actual %0d", want.duration,
                   res_data_i[51:10]);
            err_cnt++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == SHOW_EN_ADDR) begin
        show_en = pwdata_i[0];
      end
      if (req_valid_i && req_ready_i) begin
        due_results.push_back(apply_request(req_user_i[1:0], req_data_i, req_user_i[2]));
      end
    end
    pending = due_results.size();
  end

endmodule

/* tb/sv/tb_timed_cue_lookup_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_cue_lookup_top
// Stimulus and verdict for the timed cue lookup block. A directed opening
// walks the special cases of loading, searching and clearing; random
// sessions then build mostly sorted cue tables and query them with
// playback-like and random times under three idle mixes. A separate
// checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_timed_cue_lookup_top;
  import tcl_pkg::*;

  localparam int          CLK_PERIOD       = 4;
  localparam int          RESET_CYCLES     = 8;
  localparam int          QUIET_LIMIT      = 5000;
  localparam int          DRAIN_CYCLES     = 40;
  localparam int          ITEMS_PER_PHASE  = 250;
  localparam logic [1:0]  ADDR_SHOW_ENABLE = 2'd0;
  localparam logic [1:0]  OP_RSVD          = 2'd3;  // operation code with no meaning
  localparam logic [30:0] MS_MAX           = 31'h7FFF_FFFF;
  localparam logic [41:0] PTS_MAX          = 42'h3FF_FFFF_FFFF;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        s_valid       = 1'b0;
  logic        s_ready;
  logic [79:0] s_data        = '0;
  logic [2:0]  s_user        = '0;
  logic        m_valid;
  logic        m_ready       = 1'b0;
  logic [55:0] m_data;
  logic [2:0]  m_user;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [1:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  int          err_cnt;
  int          pending;
  int          checked;
  int          src_idle      = 0;
  int          sink_idle     = 0;
  int          n_sent        = 0;
  int          n_toggles     = 0;
  int          quiet         = 0;
  logic        show_now      = 1'b0;

  timed_cue_lookup_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  tcl_cue_checker #(
    .DEPTH        (MAX_CUES_DEF),
    .SHOW_EN_ADDR (ADDR_SHOW_ENABLE)
  ) checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (s_valid),
    .req_ready_i (s_ready),
    .req_data_i  (s_data),
    .req_user_i  (s_user),
    .res_valid_i (m_valid),
    .res_ready_i (m_ready),
    .res_data_i  (m_data),
    .res_user_i  (m_user),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Result side back-pressure
  always @(posedge clk) begin
    m_ready <= ($urandom_range(99) >= sink_idle);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer, %0d results pending",
               quiet, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // One request; returns at the edge where it was taken, valid still high
  task automatic send_req(input logic [1:0] op, input logic [30:0] ms, input logic txt,
                          input logic [41:0] pts, input logic pts_ok);
    logic took;
    while ($urandom_range(99) < src_idle) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {6'd0, pts, txt, ms};
    s_user  <= {pts_ok, op};
    do begin
      @(negedge clk);
      took = s_ready;
      @(posedge clk);
    end while (!took);
    n_sent++;
  endtask

  // Hold off requests until every outstanding result has been seen
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] addr, input logic [31:0] val);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_display(input logic en);
    wait_idle();
    apb_write(ADDR_SHOW_ENABLE, {31'd0, en});
    show_now = en;
    n_toggles++;
  endtask

  // Random 42-bit value over the whole field
  function automatic logic [41:0] rand_pts();
    return 42'({$urandom(), $urandom()});
  endfunction

  // Build a table and play against it
  task automatic run_session(input int min_loads, input int max_loads, input int max_q);
    int                n;
    int                q;
    int                pick;
    logic [30:0]       ms;
    logic [30:0]       first_ms;
    logic [30:0]       last_ms;
    longint unsigned   step;
    longint unsigned   lo_t;
    longint unsigned   hi_t;
    logic [41:0]       pts;
    logic [1:0]        op;
    if ($urandom_range(9) != 0) begin
      send_req(OP_CLEAR, 31'($urandom()), 1'($urandom()), rand_pts(), 1'($urandom()));
    end
    n  = $urandom_range(min_loads, max_loads);
    ms = ($urandom_range(4) == 0) ? 31'($urandom_range(32'h7F00_0000)) :
                                    31'($urandom_range(10000));
    first_ms = ms;
    last_ms  = ms;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 12)      step = 0;                               // same start
      else if (pick < 25) step = 64'($urandom_range(1, 199));     // under the minimum
      else                step = 64'($urandom_range(200, 8000));
      if (pick >= 92) begin
        ms = 31'($urandom());                                     // out of order
      end else if (longint'(ms) + step > longint'(MS_MAX)) begin
        ms = MS_MAX;
      end else begin
        ms = 31'(ms + step);
      end
      if (ms > last_ms) last_ms = ms;
      send_req(OP_LOAD, ms, ($urandom_range(4) != 0), rand_pts(), 1'($urandom()));
    end
    // playback-like times around the table, some jumps and noise
    q    = $urandom_range(2, max_q);
    lo_t = longint'(first_ms) * 1000;
    lo_t = (lo_t > 1000000) ? lo_t - 1000000 : 0;
    hi_t = longint'(last_ms) * 1000 + 9000000;
    pts  = 42'(lo_t);
    for (int i = 0; i < q; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)      pts = pts + 42'($urandom_range(400000));
      else if (pick < 90) pts = 42'(lo_t + ({$urandom(), $urandom()} % (hi_t - lo_t + 1)));
      else                pts = rand_pts();
      pick = $urandom_range(39);
      if (pick == 0)      op = OP_RSVD;
      else if (pick == 1) op = OP_LOAD;
      else                op = OP_QUERY;
      send_req(op, 31'($urandom()), 1'($urandom()), pts, ($urandom_range(15) != 0));
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: display off, nothing current
    send_req(OP_QUERY, '0, 1'b0, 42'd0, 1'b1);
    // table with a short gap, a textless cue and the latest start
    send_req(OP_LOAD, 31'd0, 1'b1, '0, 1'b0);
    send_req(OP_LOAD, 31'd100, 1'b1, '0, 1'b0);
    send_req(OP_LOAD, 31'd1000, 1'b0, '0, 1'b0);
    send_req(OP_LOAD, 31'd5000, 1'b1, '0, 1'b0);
    send_req(OP_LOAD, MS_MAX, 1'b1, PTS_MAX, 1'b1);
    set_display(1'b1);
    send_req(OP_QUERY, MS_MAX, 1'b1, 42'd0, 1'b0);        // invalid time
    send_req(OP_QUERY, '0, 1'b0, 42'd0, 1'b1);            // cue 0, minimum duration
    send_req(OP_QUERY, '0, 1'b0, 42'd99999, 1'b1);        // same cue again
    send_req(OP_QUERY, '0, 1'b0, 42'd1000000, 1'b1);      // cue without text
    send_req(OP_QUERY, '0, 1'b0, 42'd5000000, 1'b1);      // long gap
    send_req(OP_QUERY, '0, 1'b0, PTS_MAX, 1'b1);          // last cue
    send_req(OP_RSVD, MS_MAX, 1'b1, PTS_MAX, 1'b1);       // unused code
    set_display(1'b0);
    send_req(OP_QUERY, '0, 1'b0, 42'd0, 1'b1);            // drops current cue
    send_req(OP_QUERY, '0, 1'b0, 42'd0, 1'b1);            // nothing left to drop
    send_req(OP_LOAD, 31'd9000, 1'b1, '0, 1'b0);          // load while disabled
    set_display(1'b1);
    send_req(OP_CLEAR, MS_MAX, 1'b1, PTS_MAX, 1'b1);
    send_req(OP_QUERY, '0, 1'b0, 42'd0, 1'b1);            // empty table
    send_req(OP_LOAD, 31'd500, 1'b1, '0, 1'b0);
    send_req(OP_LOAD, 31'd200, 1'b1, '0, 1'b0);           // out of order
    send_req(OP_QUERY, '0, 1'b0, 42'd100000, 1'b1);       // before every cue
    send_req(OP_QUERY, '0, 1'b0, 42'd600000, 1'b1);
    send_req(OP_QUERY, '0, 1'b0, 42'd500000, 1'b1);

    // random sessions under three idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      int target;
      case (phase)
        0:       begin src_idle = 24; sink_idle = 61; end
        1:       begin src_idle = 61; sink_idle = 24; end
        default: begin src_idle = 0;  sink_idle = 0;  end
      endcase
      target = n_sent + ITEMS_PER_PHASE;
      while (n_sent < target) begin
        if ($urandom_range(5) == 0)  set_display(1'b0);
        else if (!show_now)          set_display(1'b1);
        run_session(1, ($urandom_range(7) == 0) ? 200 : 24, 50);
      end
    end

    // drain and settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests over three idle mixes, tables up to 200 cues",
             n_sent);
    $display("Compared %0d results; display setting written %0d times", checked,
             n_toggles);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
